// ===== rtl/core/tprs_pkg.sv =====
// Shared types and constants for the timer prescaler/reload search core.
// Holds field widths, status codes, FSM states and the structs between modules.
// Depends on nothing.
package tprs_pkg;

  localparam int unsigned RELOAD_BITS = 32;

  localparam int unsigned CLK_W = 32;
  localparam int unsigned TGT_W = 43;
  localparam int unsigned LIM_W = 32;
  localparam int unsigned OUT_W = 32;
  localparam int unsigned TOT_W = 42;
  localparam int unsigned CNT_W = 22;
  localparam int unsigned FD_W  = 17;
  localparam int unsigned SQ_W  = 2 * CNT_W;
  localparam int unsigned DIV_STEPS_W = 6;

  localparam logic [TOT_W-1:0] MS_PER_HZ  = TOT_W'(1000);
  localparam logic [CNT_W-1:0] QUOT_MAX   = CNT_W'(65536);
  localparam logic [CNT_W-1:0] P2_START   = CNT_W'(65537);
  localparam logic [LIM_W:0]   RELOAD_CAP = (33'd1 << RELOAD_BITS) - 33'd1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TOT_DIV,
    ST_TOT_WAIT,
    ST_P1_DIV,
    ST_P1_WAIT,
    ST_FAIL,
    ST_P2_SQ,
    ST_P2_TEST,
    ST_P2_WAIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic             start;
    logic [TOT_W-1:0] dividend;
    logic [TGT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [TOT_W-1:0] quot;
    logic [TGT_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic             status;
    logic [OUT_W-1:0] prescaler;
    logic [OUT_W-1:0] reload;
  } result_t;

endpackage

// ===== rtl/core/tprs_if.sv =====
// Valid/ready channel interfaces for the search core: request and result.
// Depends on tprs_pkg for the field widths.
interface tprs_in_if;
  logic                            valid;
  logic                            ready;
  logic [tprs_pkg::CLK_W-1:0]      clock_hz;
  logic [tprs_pkg::TGT_W-1:0]      target_millihertz;
  logic [tprs_pkg::LIM_W-1:0]      reload_limit;

  modport source (output valid, output clock_hz, output target_millihertz,
                  output reload_limit, input ready);
  modport sink   (input valid, input clock_hz, input target_millihertz,
                  input reload_limit, output ready);
endinterface

interface tprs_out_if;
  logic                            valid;
  logic                            ready;
  logic                            status;
  logic [tprs_pkg::OUT_W-1:0]      prescaler;
  logic [tprs_pkg::OUT_W-1:0]      reload;

  modport source (output valid, output status, output prescaler, output reload,
                  input ready);
  modport sink   (input valid, input status, input prescaler, input reload,
                  output ready);
endinterface

// ===== rtl/core/timer_prescaler_reload_search_core.sv =====
// Timer prescaler/reload search core: top level with the result register.
// Depends on tprs_pkg, tprs_if, tprs_div and tprs_ctrl.
//
// Usage: one request beat on in_i (timer clock in Hz, target in mHz, reload
// limit) yields one result beat on out_o (status, prescaler, reload).
// in_i.ready is high only while the sequencer is idle; one request is in
// work at a time, and a new request is taken while the previous result
// still sits in the output register.
// A zero target is answered without a search. Otherwise the divider first
// forms the tick total, then tries one quotient per pass (up to 65536
// tries). If no exact pair exists and the total has no factor from 2 up
// to 65536, the divisor scan goes on, one candidate per divider pass, up
// to the square root of the total or the reload limit plus one, whichever
// is lower. Every try is one pass of the single bit-serial 42-bit divider.
// Reset clears the sequencer, the divider and the output valid flag.
// While out_o.ready is low the result holds in the output register; a
// finished search after it waits in the sequencer until the register frees.
module timer_prescaler_reload_search_core (
  input  logic  clk_i,
  input  logic  rst_ni,
  tprs_in_if.sink    in_i,
  tprs_out_if.source out_o
);

  tprs_pkg::div_req_t  div_req;
  tprs_pkg::div_rsp_t  div_rsp;
  tprs_pkg::result_t   res;
  tprs_pkg::result_t   out_q;
  logic                res_valid;
  logic                res_ready;
  logic                out_valid_q, out_valid_d;

  tprs_ctrl u_ctrl (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_i.valid),
    .in_ready_o          (in_i.ready),
    .clock_hz_i          (in_i.clock_hz),
    .target_millihertz_i (in_i.target_millihertz),
    .reload_limit_i      (in_i.reload_limit),
    .div_req_o           (div_req),
    .div_rsp_i           (div_rsp),
    .res_valid_o         (res_valid),
    .res_ready_i         (res_ready),
    .res_o               (res)
  );

  tprs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign res_ready = !out_valid_q || out_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.status    = out_q.status;
  assign out_o.prescaler = out_q.prescaler;
  assign out_o.reload    = out_q.reload;

endmodule

// ===== rtl/core/tprs_div.sv =====
// Shared restoring divider, one quotient bit per cycle, 42-bit dividend.
// Depends on tprs_pkg for div_req_t and div_rsp_t.
module tprs_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tprs_pkg::div_req_t  req_i,
  output tprs_pkg::div_rsp_t  rsp_o
);

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [tprs_pkg::DIV_STEPS_W-1:0] cnt_q, cnt_d;
  logic [tprs_pkg::TOT_W-1:0]      dvd_q, dvd_d;
  logic [tprs_pkg::TGT_W-1:0]      rem_q, rem_d;
  logic [tprs_pkg::TGT_W-1:0]      dsr_q, dsr_d;
  logic [tprs_pkg::TGT_W:0]        trial;
  logic                            ge;

  assign trial = {rem_q, dvd_q[tprs_pkg::TOT_W-1]};
  assign ge    = (trial >= {1'b0, dsr_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = tprs_pkg::DIV_STEPS_W'(tprs_pkg::TOT_W);
      dvd_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      dvd_d = {dvd_q[tprs_pkg::TOT_W-2:0], ge};
      rem_d = ge ? tprs_pkg::TGT_W'(trial - {1'b0, dsr_q}) : trial[tprs_pkg::TGT_W-1:0];
      cnt_d = cnt_q - tprs_pkg::DIV_STEPS_W'(1);
      if (cnt_q == tprs_pkg::DIV_STEPS_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = dvd_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ===== rtl/core/tprs_ctrl.sv =====
// Search sequencer: forms the tick total, scans quotients, then falls back
// to the smallest-divisor scan. Drives the shared divider. Depends on tprs_pkg.
module tprs_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tprs_pkg::CLK_W-1:0]    clock_hz_i,
  input  logic [tprs_pkg::TGT_W-1:0]    target_millihertz_i,
  input  logic [tprs_pkg::LIM_W-1:0]    reload_limit_i,
  output tprs_pkg::div_req_t            div_req_o,
  input  tprs_pkg::div_rsp_t            div_rsp_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output tprs_pkg::result_t             res_o
);

  tprs_pkg::state_e                state_q, state_d;
  logic [tprs_pkg::TGT_W-1:0]      tgt_q, tgt_d;
  logic [tprs_pkg::LIM_W:0]        top_q, top_d;
  logic [tprs_pkg::TOT_W-1:0]      total_q, total_d;
  logic [tprs_pkg::CNT_W-1:0]      cnt_q, cnt_d;
  logic                            fd_valid_q, fd_valid_d;
  logic [tprs_pkg::FD_W-1:0]       fd_q, fd_d;
  logic [tprs_pkg::TOT_W-1:0]      fd_quot_q, fd_quot_d;
  logic [tprs_pkg::SQ_W-1:0]       sq_q, sq_d;
  tprs_pkg::result_t               res_q, res_d;

  logic                            accept;
  logic [tprs_pkg::LIM_W:0]        lim_sat;
  logic                            rem_zero;
  logic                            p1_hit;
  logic                            p2_stop;
  logic                            fd_in_range;

  assign accept   = in_valid_i && in_ready_o;
  assign lim_sat  = ({1'b0, reload_limit_i} > tprs_pkg::RELOAD_CAP) ?
                    tprs_pkg::RELOAD_CAP : {1'b0, reload_limit_i};
  assign rem_zero = (div_rsp_i.rem == '0);
  assign p1_hit   = rem_zero && (div_rsp_i.quot >= tprs_pkg::TOT_W'(2)) &&
                    (div_rsp_i.quot <= tprs_pkg::TOT_W'(top_q));
  assign p2_stop  = ((tprs_pkg::LIM_W + 1)'(cnt_q) > top_q) ||
                    (sq_q > tprs_pkg::SQ_W'(total_q));
  assign fd_in_range = ((tprs_pkg::LIM_W + 1)'(fd_q) <= top_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tprs_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = (target_millihertz_i == '0) ? tprs_pkg::ST_DONE : tprs_pkg::ST_TOT_DIV;
        end
      end
      tprs_pkg::ST_TOT_DIV: state_d = tprs_pkg::ST_TOT_WAIT;
      tprs_pkg::ST_TOT_WAIT: begin
        if (div_rsp_i.done) begin
          if (top_q == (tprs_pkg::LIM_W + 1)'(1) || div_rsp_i.quot == '0) begin
            state_d = tprs_pkg::ST_DONE;
          end else begin
            state_d = tprs_pkg::ST_P1_DIV;
          end
        end
      end
      tprs_pkg::ST_P1_DIV: state_d = tprs_pkg::ST_P1_WAIT;
      tprs_pkg::ST_P1_WAIT: begin
        if (div_rsp_i.done) begin
          priority if (p1_hit) begin
            state_d = tprs_pkg::ST_DONE;
          end else if (cnt_q == tprs_pkg::QUOT_MAX) begin
            state_d = tprs_pkg::ST_FAIL;
          end else begin
            state_d = tprs_pkg::ST_P1_DIV;
          end
        end
      end
      tprs_pkg::ST_FAIL: begin
        state_d = fd_valid_q ? tprs_pkg::ST_DONE : tprs_pkg::ST_P2_SQ;
      end
      tprs_pkg::ST_P2_SQ: state_d = tprs_pkg::ST_P2_TEST;
      tprs_pkg::ST_P2_TEST: begin
        state_d = p2_stop ? tprs_pkg::ST_DONE : tprs_pkg::ST_P2_WAIT;
      end
      tprs_pkg::ST_P2_WAIT: begin
        if (div_rsp_i.done) begin
          state_d = rem_zero ? tprs_pkg::ST_DONE : tprs_pkg::ST_P2_SQ;
        end
      end
      tprs_pkg::ST_DONE: begin
        if (res_ready_i) begin
          state_d = tprs_pkg::ST_IDLE;
        end
      end
      default: state_d = tprs_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o         = 1'b0;
    res_valid_o        = 1'b0;
    div_req_o.start    = 1'b0;
    div_req_o.dividend = total_q;
    div_req_o.divisor  = tprs_pkg::TGT_W'(cnt_q);
    unique case (state_q)
      tprs_pkg::ST_IDLE: in_ready_o = 1'b1;
      tprs_pkg::ST_TOT_DIV: begin
        div_req_o.start   = 1'b1;
        div_req_o.divisor = tgt_q;
      end
      tprs_pkg::ST_P1_DIV: div_req_o.start = 1'b1;
      tprs_pkg::ST_P2_TEST: div_req_o.start = !p2_stop;
      tprs_pkg::ST_DONE: res_valid_o = 1'b1;
      default: ;
    endcase
  end

  assign res_o = res_q;

  // datapath
  always_comb begin
    tgt_d      = tgt_q;
    top_d      = top_q;
    total_d    = total_q;
    cnt_d      = cnt_q;
    fd_valid_d = fd_valid_q;
    fd_d       = fd_q;
    fd_quot_d  = fd_quot_q;
    sq_d       = sq_q;
    res_d      = res_q;
    unique case (state_q)
      tprs_pkg::ST_IDLE: begin
        tgt_d   = target_millihertz_i;
        top_d   = lim_sat + (tprs_pkg::LIM_W + 1)'(1);
        total_d = tprs_pkg::TOT_W'(clock_hz_i) * tprs_pkg::MS_PER_HZ;
        res_d   = '{status: tprs_pkg::STATUS_FAIL, prescaler: '0, reload: '0};
      end
      tprs_pkg::ST_TOT_WAIT: begin
        total_d    = div_rsp_i.quot;
        cnt_d      = tprs_pkg::CNT_W'(1);
        fd_valid_d = 1'b0;
        if (div_rsp_i.done && top_q != (tprs_pkg::LIM_W + 1)'(1) &&
            div_rsp_i.quot == '0) begin
          res_d.prescaler = '1;
        end
      end
      tprs_pkg::ST_P1_WAIT: begin
        if (div_rsp_i.done) begin
          if (rem_zero && cnt_q != tprs_pkg::CNT_W'(1) && !fd_valid_q) begin
            fd_valid_d = 1'b1;
            fd_d       = tprs_pkg::FD_W'(cnt_q);
            fd_quot_d  = div_rsp_i.quot;
          end
          if (p1_hit) begin
            res_d.status    = tprs_pkg::STATUS_OK;
            res_d.prescaler = tprs_pkg::OUT_W'(cnt_q - tprs_pkg::CNT_W'(1));
            res_d.reload    = tprs_pkg::OUT_W'(div_rsp_i.quot - tprs_pkg::TOT_W'(1));
          end
          cnt_d = cnt_q + tprs_pkg::CNT_W'(1);
        end
      end
      tprs_pkg::ST_FAIL: begin
        cnt_d = tprs_pkg::P2_START;
        if (fd_valid_q && fd_in_range) begin
          res_d.prescaler = tprs_pkg::OUT_W'(fd_quot_q - tprs_pkg::TOT_W'(1));
        end
      end
      tprs_pkg::ST_P2_SQ: sq_d = tprs_pkg::SQ_W'(cnt_q) * tprs_pkg::SQ_W'(cnt_q);
      tprs_pkg::ST_P2_WAIT: begin
        if (div_rsp_i.done) begin
          if (rem_zero) begin
            res_d.prescaler = tprs_pkg::OUT_W'(div_rsp_i.quot - tprs_pkg::TOT_W'(1));
          end
          cnt_d = cnt_q + tprs_pkg::CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= tprs_pkg::ST_IDLE;
      fd_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      fd_valid_q <= fd_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tgt_q     <= tgt_d;
    top_q     <= top_d;
    total_q   <= total_d;
    cnt_q     <= cnt_d;
    fd_q      <= fd_d;
    fd_quot_q <= fd_quot_d;
    sq_q      <= sq_d;
    res_q     <= res_d;
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Testbench for timer_prescaler_reload_search_core: table-driven and random requests,
// each result beat checked against a table result or a built-in prescaler/reload solver.
// Depends on tprs_pkg, tprs_if and the core RTL.
module tb;
  import tprs_pkg::*;

  localparam int DIR_N = 21;
  localparam int RAND_N = 100;
  localparam longint unsigned MHZ_MAX = 64'h7FF_FFFF_FFFF;

  typedef struct packed {
    logic [CLK_W-1:0] hz;
    logic [TGT_W-1:0] mhz;
    logic [LIM_W-1:0] lim;
    logic             known;
    result_t          res;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tprs_in_if  in_ch ();
  tprs_out_if out_ch ();

  timer_prescaler_reload_search_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  dir_row_t        dir_tab [0:DIR_N-1];
  result_t         awaited [$];
  result_t         front;
  int              errors = 0;
  int              checked = 0;
  int              burst_left = 0;
  int              stall_mode = 0;
  int              stall_left = 0;
  longint unsigned cycle_cnt = 0;
  longint unsigned cycle_limit = 50000;

  always #5 clk_i = ~clk_i;

  function automatic dir_row_t row(input logic [CLK_W-1:0] hz, input logic [TGT_W-1:0] mhz,
                                   input logic [LIM_W-1:0] lim, input logic known,
                                   input logic st, input logic [OUT_W-1:0] psc,
                                   input logic [OUT_W-1:0] rl);
    return {hz, mhz, lim, known, st, psc, rl};
  endfunction

  function automatic longint unsigned rand_between(input longint unsigned lo,
                                                   input longint unsigned hi);
    if (hi <= lo) return lo;
    return lo + ({$urandom, $urandom} % (hi - lo + 1));
  endfunction

  // Search the largest reload with an exact quotient whose prescaler fits 16 bits.
  function automatic result_t solve_timer(input logic [CLK_W-1:0] hz,
                                          input logic [TGT_W-1:0] mhz,
                                          input logic [LIM_W-1:0] lim_in,
                                          output longint unsigned work);
    longint unsigned hz64, mhz64, lim, top, total, q, d, c;
    result_t r;
    hz64 = hz;
    mhz64 = mhz;
    lim = lim_in;
    if (lim > RELOAD_CAP) lim = RELOAD_CAP;
    r.status = STATUS_FAIL;
    r.prescaler = '0;
    r.reload = '0;
    work = QUOT_MAX;
    if (mhz64 == 0) return r;
    total = (hz64 * MS_PER_HZ) / mhz64;
    top = lim + 1;
    if (lim == 0) return r;
    if (total == 0) begin
      r.prescaler = '1;
      return r;
    end
    for (q = 1; q <= QUOT_MAX; q++) begin
      if (total % q == 0) begin
        d = total / q;
        if (d >= 2 && d <= top) begin
          work = q;
          r.status = STATUS_OK;
          r.prescaler = OUT_W'(q - 1);
          r.reload = OUT_W'(d - 1);
          return r;
        end
      end
    end
    // fall back to the smallest divisor the scan would have rejected last
    d = 0;
    for (c = 2; c <= top && c * c <= total; c++) begin
      work++;
      if (total % c == 0) begin
        d = c;
        break;
      end
    end
    if (d == 0 && total >= 2 && total <= top) d = total;
    if (d != 0) r.prescaler = OUT_W'(total / d - 1);
    return r;
  endfunction

  function automatic dir_row_t make_random();
    longint unsigned r, q, qmax, total, tmax, hz, mhz, lim;
    int pick;
    pick = $urandom_range(0, 99);
    hz = $urandom;
    lim = $urandom;
    mhz = 0;
    if (pick < 63) begin
      // build total = q * (reload + 1) so an exact pair exists at a small quotient
      r = $urandom;
      r = r >> (32 - $urandom_range(1, 32));
      if (r == 0) r = 1;
      if (r > 64'hFFFF_FFFE) r = 64'hFFFF_FFFE;
      qmax = 64'hFFFF_FFFF / (r + 1);
      if (qmax > 64) qmax = 64;
      q = $urandom_range(qmax, 1);
      total = q * (r + 1);
      tmax = 64'hFFFF_FFFF * 1000 / total;
      if (tmax > MHZ_MAX) tmax = MHZ_MAX;
      mhz = rand_between(1000, tmax);
      hz = (total * mhz + 999) / 1000;
      case ($urandom_range(0, 2))
        0: lim = r;
        1: begin
          lim = r + $urandom_range(0, 16);
          if (lim > 64'hFFFF_FFFF) lim = 64'hFFFF_FFFF;
        end
        default: lim = $urandom_range(32'hFFFF_FFFF, r);
      endcase
    end else if (pick < 68) begin
      case ($urandom_range(0, 4))
        0: mhz = 1;
        1: mhz = 2;
        2: mhz = 4;
        3: mhz = 5;
        default: mhz = 8;
      endcase
      if (hz < 2) hz = 2;
      lim = $urandom_range(32'hFFFF_FFFF, hz - 1);
    end else if (pick < 78) begin
      hz = $urandom_range(32'hFFFF_FFFF, 2);
      mhz = rand_between(1000, hz * 500);
      total = hz * 1000 / mhz;
      lim = $urandom_range(32'hFFFF_FFFF, total - 1);
    end else if (pick < 89) begin
      mhz = rand_between(hz * 1000 + 1, MHZ_MAX);
    end else if (pick < 94) begin
      mhz = 0;
    end else begin
      lim = 0;
      mhz = rand_between(1, MHZ_MAX);
    end
    return row(CLK_W'(hz), TGT_W'(mhz), LIM_W'(lim), 1'b0, 1'b0, '0, '0);
  endfunction

  task automatic send_req(input dir_row_t item);
    result_t want;
    longint unsigned work;
    int gap;
    want = solve_timer(item.hz, item.mhz, item.lim, work);
    if (item.known) want = item.res;
    cycle_limit += 4 * (50 * work + 300);
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap != 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    in_ch.valid = 1'b1;
    in_ch.clock_hz = item.hz;
    in_ch.target_millihertz = item.mhz;
    in_ch.reload_limit = item.lim;
    do @(posedge clk_i); while (!in_ch.ready);
    awaited.push_back(want);
  endtask

  // Hold off the sender until every outstanding result has come back.
  task automatic drain();
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    burst_left = 0;
    while (awaited.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, actual %0b/%0h/%0h", $time,
                 out_ch.status, out_ch.prescaler, out_ch.reload);
      end else begin
        front = awaited.pop_front();
        checked++;
        check_field("status", front.status, out_ch.status);
        check_field("prescaler", front.prescaler, out_ch.prescaler);
        check_field("reload", front.reload, out_ch.reload);
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(4, 40);
    end
    stall_left--;
    case (stall_mode)
      0: out_ch.ready = 1'b1;
      1: out_ch.ready = ($urandom_range(0, 3) != 0);
      default: out_ch.ready = 1'b0;
    endcase
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > cycle_limit) begin
      $display("%0t: cycle limit %0d reached, %0d results outstanding", $time, cycle_limit,
               awaited.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int i;
    in_ch.valid = 1'b0;
    in_ch.clock_hz = '0;
    in_ch.target_millihertz = '0;
    in_ch.reload_limit = '0;
    out_ch.ready = 1'b0;

    dir_tab[0]  = row(32'hFFFF_FFFF, 43'd0, 32'hFFFF_FFFF, 1'b1, STATUS_FAIL, '0, '0);
    dir_tab[1]  = row(32'd0, 43'd0, 32'd0, 1'b1, STATUS_FAIL, '0, '0);
    dir_tab[2]  = row(32'd1000, 43'd1000, 32'd0, 1'b1, STATUS_FAIL, '0, '0);
    dir_tab[3]  = row(32'd0, 43'd1, 32'hFFFF_FFFF, 1'b1, STATUS_FAIL, '1, '0);
    dir_tab[4]  = row(32'd1, 43'h7FF_FFFF_FFFF, 32'd1, 1'b1, STATUS_FAIL, '1, '0);
    dir_tab[5]  = row(32'hFFFF_FFFF, 43'h7FF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1, STATUS_FAIL,
                      '1, '0);
    dir_tab[6]  = row(32'd1000, 43'd1000, 32'hFFFF_FFFF, 1'b1, STATUS_OK, '0, 32'd999);
    dir_tab[7]  = row(32'hFFFF_FFFF, 43'd1000, 32'hFFFF_FFFF, 1'b1, STATUS_OK, '0,
                      32'hFFFF_FFFE);
    dir_tab[8]  = row(32'd2, 43'd1000, 32'd1, 1'b1, STATUS_OK, '0, 32'd1);
    dir_tab[9]  = row(32'hFFFF_FFFF, 43'd1, 32'hFFFF_FFFF, 1'b0, 1'b0, '0, '0);
    dir_tab[10] = row(32'd300, 43'd1000, 32'd99, 1'b0, 1'b0, '0, '0);
    dir_tab[11] = row(32'd300, 43'd1000, 32'd98, 1'b0, 1'b0, '0, '0);
    dir_tab[12] = row(32'd65521, 43'd1000, 32'hFFFF_FFFF, 1'b0, 1'b0, '0, '0);
    dir_tab[13] = row(32'hAAAA_AAAA, 43'd1000, 32'h5555_5555, 1'b0, 1'b0, '0, '0);
    dir_tab[14] = row(32'h5555_5555, 43'd1000, 32'hAAAA_AAAA, 1'b0, 1'b0, '0, '0);
    dir_tab[15] = row(32'd1, 43'd1000, 32'hFFFF_FFFF, 1'b0, 1'b0, '0, '0);
    dir_tab[16] = row(32'd131074, 43'd1000, 32'd1, 1'b0, 1'b0, '0, '0);
    dir_tab[17] = row(32'd4290934214, 43'd999, 32'd65536, 1'b0, 1'b0, '0, '0);
    dir_tab[18] = row(32'hFFFF_FFFF, 43'h155_5555_5555, 32'hFFFF_FFFF, 1'b0, 1'b0, '0, '0);
    dir_tab[19] = row(32'd1, 43'd1, 32'd1, 1'b0, 1'b0, '0, '0);
    dir_tab[20] = row(32'h8000_0000, 43'h400_0000_0000, 32'h8000_0000, 1'b1, STATUS_FAIL,
                      '1, '0);

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    for (i = 0; i < DIR_N; i++) send_req(dir_tab[i]);
    drain();
    for (i = 0; i < RAND_N; i++) begin
      if (i == RAND_N / 2) drain();
      send_req(make_random());
    end

    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (awaited.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("Ran %0d table rows and %0d random requests (exact pairs, zero target,", DIR_N,
             RAND_N);
    $display("zero limit, zero total, no-pair searches); %0d result beats compared, %0d errors",
             checked, errors);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/tprs_pkg.sv
rtl/core/tprs_if.sv
rtl/core/tprs_div.sv
rtl/core/tprs_ctrl.sv
rtl/core/timer_prescaler_reload_search_core.sv
test/tb.sv
